### src/phase_success_ranker_unit_defines.svh
// Assertion macros shared by the checker of the phase success ranker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef PHASE_SUCCESS_RANKER_UNIT_DEFINES_SVH
`define PHASE_SUCCESS_RANKER_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define PSR_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

### src/psr_pkg.sv
// Shared types, constants and helpers of the phase success ranker.
// No dependencies; imported by every module of the block.
`default_nettype none

package psr_pkg;

  localparam int PHASE_COUNT = 16;
  localparam int COUNT_BITS  = 31;
  localparam int IDX_BITS    = $clog2(PHASE_COUNT);

  typedef logic [IDX_BITS-1:0]   phase_idx_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [COUNT_BITS:0]   count_ext_t;

  typedef enum logic [1:0] {
    OP_SUBMIT  = 2'd0,
    OP_REORDER = 2'd1,
    OP_QUERY   = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  // Phase characters in phase number order: "897A6B5C4D3E2F10".
  localparam logic [7:0] PHASE_CHARS [16] = '{
    8'h38, 8'h39, 8'h37, 8'h41, 8'h36, 8'h42, 8'h35, 8'h43,
    8'h34, 8'h44, 8'h33, 8'h45, 8'h32, 8'h46, 8'h31, 8'h30
  };

  // One ranked slot: the phase and its success counter.
  typedef struct packed {
    phase_idx_t phase;
    count_t     count;
  } slot_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic       clear;
    logic       submit;
    phase_idx_t hit_phase;
    logic [7:0] sectors;
    logic       sort;
    logic       parity;
  } cell_ctrl_t;

  typedef struct packed {
    logic       hit;
    phase_idx_t idx;
  } phase_match_t;

  // Map a phase character to its phase number.
  function automatic phase_match_t match_phase(input logic [7:0] code);
    phase_match_t m;
    m.hit = 1'b0;
    m.idx = '0;
    for (int p = PHASE_COUNT - 1; p >= 0; p--) begin
      if (PHASE_CHARS[p] == code) begin
        m.hit = 1'b1;
        m.idx = phase_idx_t'(p);
      end
    end
    return m;
  endfunction

  // True when slot a ranks ahead of slot b: higher count, then lower phase.
  function automatic logic slot_beats(input slot_t a, input slot_t b);
    return (a.count > b.count) || ((a.count == b.count) && (a.phase < b.phase));
  endfunction

endpackage

`default_nettype wire

### src/phase_success_ranker_unit.sv
// Phase success ranker: a row of rank cells and a sequencer.
// Uses psr_pkg, psr_ctrl and psr_cell.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries op_i, phase_code_i,
//   sectors_i and rank_i. Submit adds sectors to the counter of the phase
//   named by phase_code_i (saturating); an unknown character does nothing.
//   Reorder sorts the rank cells by counter, highest first, lower phase
//   number on ties. Query answers the phase character at rank_i (rank 0
//   when rank_i is out of range). Clear restores zero counters and the
//   identity order.
//   A query result shows on out_valid_o the cycle after acceptance and is
//   held until out_ready_i takes it; while it waits, in_ready_o stays low,
//   so no transaction of any kind is taken until the pending result leaves.
//   A reorder runs PHASE_COUNT odd-even compare-exchange passes through
//   the cell row, one per cycle, and in_ready_o stays low while they run.
//   Reset (rst_ni low) clears counters, restores the identity order and
//   drops out_valid_o.
`default_nettype none

module phase_success_ranker_unit import psr_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [1:0]  op_i,
  input  wire [7:0]  phase_code_i,
  input  wire [7:0]  sectors_i,
  input  wire [7:0]  rank_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] phase_out_o
);

  cell_ctrl_t ctrl;
  slot_t      slot_w  [PHASE_COUNT];
  logic       beats_w [PHASE_COUNT];
  phase_idx_t rank_sel;
  logic [7:0] query_char;

  // Pick the ranked slot for a query
  assign rank_sel   = (rank_i >= 8'(PHASE_COUNT)) ? '0 : rank_i[IDX_BITS-1:0];
  assign query_char = PHASE_CHARS[slot_w[rank_sel].phase];

  psr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .phase_code_i (phase_code_i),
    .sectors_i    (sectors_i),
    .query_char_i (query_char),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phase_out_o  (phase_out_o),
    .ctrl_o       (ctrl)
  );

  // Row of rank cells, each linked to its neighbors
  for (genvar g = 0; g < PHASE_COUNT; g++) begin : g_cell
    slot_t left_s;
    slot_t right_s;
    logic  right_beats;

    if (g == 0) begin : g_first
      assign left_s = slot_w[g];
    end else begin : g_mid_l
      assign left_s = slot_w[g-1];
    end

    if (g == PHASE_COUNT - 1) begin : g_last
      assign right_s     = slot_w[g];
      assign right_beats = 1'b0;
    end else begin : g_mid_r
      assign right_s     = slot_w[g+1];
      assign right_beats = beats_w[g+1];
    end

    psr_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .idx_i         (phase_idx_t'(g)),
      .has_left_i    ((g != 0) ? 1'b1 : 1'b0),
      .has_right_i   ((g != PHASE_COUNT - 1) ? 1'b1 : 1'b0),
      .left_i        (left_s),
      .right_i       (right_s),
      .right_beats_i (right_beats),
      .beats_left_o  (beats_w[g]),
      .slot_o        (slot_w[g])
    );
  end

endmodule

`default_nettype wire

### src/psr_cell.sv
// One rank slot of the ranking chain: holds a phase and its counter,
// adds on submit and swaps with a neighbor during sort passes. Uses psr_pkg.
`default_nettype none

module psr_cell import psr_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  phase_idx_t idx_i,
  input  wire        has_left_i,
  input  wire        has_right_i,
  input  slot_t      left_i,
  input  slot_t      right_i,
  input  wire        right_beats_i,
  output logic       beats_left_o,
  output slot_t      slot_o
);

  slot_t      slot_q, slot_d;
  count_ext_t sum;
  logic       pair_right, pair_left;

  // Compare against the left neighbor; the left cell uses this too
  assign beats_left_o = slot_beats(slot_q, left_i);

  // Even pairs on even passes, odd pairs on odd passes
  assign pair_right = has_right_i && (idx_i[0] == ctrl_i.parity);
  assign pair_left  = has_left_i && (idx_i[0] != ctrl_i.parity);

  assign sum = count_ext_t'(slot_q.count) + count_ext_t'(ctrl_i.sectors);

  // Select next slot content
  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.clear) begin
      slot_d.phase = idx_i;
      slot_d.count = '0;
    end else if (ctrl_i.sort) begin
      if (pair_right && right_beats_i) begin
        slot_d = right_i;
      end else if (pair_left && beats_left_o) begin
        slot_d = left_i;
      end
    end else if (ctrl_i.submit && (slot_q.phase == ctrl_i.hit_phase)) begin
      slot_d.count = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q.phase <= idx_i;
      slot_q.count <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule

`default_nettype wire

### src/psr_ctrl.sv
// Sequencer of the phase success ranker: input handshake, sort pass
// counter, cell control and the output register. Uses psr_pkg.
`default_nettype none

module psr_ctrl import psr_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire [1:0]  op_i,
  input  wire [7:0]  phase_code_i,
  input  wire [7:0]  sectors_i,
  input  wire [7:0]  query_char_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic [7:0] phase_out_o,
  output cell_ctrl_t ctrl_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SORT = 2'b10
  } state_e;

  localparam phase_idx_t LastPass = phase_idx_t'(PHASE_COUNT - 1);

  state_e       state_q, state_d;
  phase_idx_t   pass_q, pass_d;
  logic         out_valid_q, out_valid_d;
  logic [7:0]   out_data_q, out_data_d;
  logic         accept;
  op_e          op;
  phase_match_t match;

  assign op     = op_e'(op_i);
  assign match  = match_phase(phase_code_i);
  assign accept = in_valid_i && in_ready_o;

  // Take a transaction when not sorting and the output slot is free or leaving
  assign in_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);

  // Sequence sort passes
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (op == OP_REORDER)) begin
          state_d = ST_SORT;
          pass_d  = '0;
        end
      end
      ST_SORT: begin
        pass_d = pass_q + phase_idx_t'(1);
        if (pass_q == LastPass) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Drive cell control
  always_comb begin
    ctrl_o.clear     = accept && (op == OP_CLEAR);
    ctrl_o.submit    = accept && (op == OP_SUBMIT) && match.hit;
    ctrl_o.hit_phase = match.idx;
    ctrl_o.sectors   = sectors_i;
    ctrl_o.sort      = (state_q == ST_SORT);
    ctrl_o.parity    = pass_q[0];
  end

  // Hold the query answer until taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && (op == OP_QUERY)) begin
      out_valid_d = 1'b1;
      out_data_d  = query_char_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign phase_out_o = out_data_q;

endmodule

`default_nettype wire

### src/psr_checker.sv
// Port-level checker of the phase success ranker, bound to the top level.
// Uses psr_pkg and phase_success_ranker_unit_defines.svh.
`default_nettype none
`include "phase_success_ranker_unit_defines.svh"

module psr_checker import psr_pkg::*; (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire [1:0] op_i,
  input wire [7:0] phase_code_i,
  input wire [7:0] sectors_i,
  input wire [7:0] rank_i,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire [7:0] phase_out_o
);

  logic in_take;
  logic out_stall;

  assign in_take   = in_valid_i && in_ready_o;
  assign out_stall = out_valid_o && !out_ready_i;

  // A stalled result holds
  `PSR_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(phase_out_o))
  // A query transaction always produces a result next cycle
  `PSR_ASSERT_NEXT(a_query_answers, in_take && (op_i == OP_QUERY), out_valid_o)
  // A reorder blocks the input when its sort begins
  `PSR_ASSERT_NEXT(a_reorder_busy, in_take && (op_i == OP_REORDER), !in_ready_o)
  // A new result only follows a query transaction
  `PSR_ASSERT_NEXT(a_no_invented, !out_valid_o && !(in_take && (op_i == OP_QUERY)), !out_valid_o)
  // No new query is taken while a result is stuck
  `PSR_ASSERT_SAME(a_query_waits, out_stall, !in_ready_o || !in_valid_i || (op_i != OP_QUERY))

endmodule

bind phase_success_ranker_unit psr_checker u_psr_checker (.*);

`default_nettype wire

### tb/phase_rank_checker.sv
// Checker for the phase success ranker: watches both channels, keeps its own
// phase counters and ranking, and compares every query answer in order.
// Depends on psr_pkg for the op codes, widths and the phase character table.
`timescale 1ns / 100ps

module phase_rank_checker import psr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [1:0] op_i,
  input  logic [7:0] phase_code_i,
  input  logic [7:0] sectors_i,
  input  logic [7:0] rank_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] phase_out_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  count_t     tally [PHASE_COUNT];
  phase_idx_t ranking [PHASE_COUNT];
  logic [7:0] awaited_chars [$];
  logic [7:0] want_char;
  int         mismatches = 0;
  int         answers_checked = 0;

  // Zero the counters and restore the identity ranking.
  function automatic void restore_initial();
    for (int p = 0; p < PHASE_COUNT; p++) begin
      tally[p]   = '0;
      ranking[p] = phase_idx_t'(p);
    end
  endfunction

  // Add sectors to the phase named by code, saturating; ignore unknown codes.
  function automatic void add_sectors(input logic [7:0] code, input logic [7:0] amount);
    count_ext_t sum;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (PHASE_CHARS[p] == code) begin
        sum      = count_ext_t'(tally[p]) + count_ext_t'(amount);
        tally[p] = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];
        return;
      end
    end
  endfunction

  // Rank by counter, highest first; strict compare keeps the lower phase on ties.
  function automatic void rerank();
    logic taken [PHASE_COUNT];
    int   best;
    for (int p = 0; p < PHASE_COUNT; p++) taken[p] = 1'b0;
    for (int r = 0; r < PHASE_COUNT; r++) begin
      best = -1;
      for (int p = 0; p < PHASE_COUNT; p++) begin
        if (!taken[p] && (best < 0 || tally[p] > tally[best])) best = p;
      end
      taken[best] = 1'b1;
      ranking[r]  = phase_idx_t'(best);
    end
  endfunction

  // Look up the character a query should answer; out-of-range ranks read rank 0.
  function automatic logic [7:0] answer_for(input logic [7:0] rk);
    int slot;
    slot = (rk >= PHASE_COUNT) ? 0 : int'(rk);
    return PHASE_CHARS[ranking[slot]];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_initial();
      awaited_chars.delete();
      pending_o    <= 0;
      fail_count_o <= mismatches;
      checked_o    <= answers_checked;
    end else begin
      // Compare a result transaction against the oldest expected answer.
      if (out_valid_i && out_ready_i) begin
        if (awaited_chars.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result 0x%02h arrived with no query outstanding",
                     $time, phase_out_i);
        end else begin
          want_char = awaited_chars.pop_front();
          answers_checked++;
          if (phase_out_i !== want_char) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] phase_out mismatch: expected 0x%02h, got 0x%02h",
                       $time, want_char, phase_out_i);
          end
        end
      end

      // Advance the prediction on every accepted input transaction.
      if (in_valid_i && in_ready_i) begin
        case (op_e'(op_i))
          OP_SUBMIT:  add_sectors(phase_code_i, sectors_i);
          OP_REORDER: rerank();
          OP_QUERY:   awaited_chars = {awaited_chars, answer_for(rank_i)};
          default:    restore_initial();
        endcase
      end

      pending_o    <= awaited_chars.size();
      fail_count_o <= mismatches;
      checked_o    <= answers_checked;
    end
  end

endmodule

### tb/phase_success_ranker_unit_test.sv
// Testbench top for the phase success ranker: drives directed and random
// transactions with bursty input and a stalling receiver, then reports.
// Depends on psr_pkg, phase_success_ranker_unit and phase_rank_checker.
`timescale 1ns / 100ps

module phase_success_ranker_unit_test;
  import psr_pkg::*;

  localparam int ITEM_TARGET  = 1650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int QUIET_EVERY  = 400;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [1:0] op_i;
  logic [7:0] phase_code_i;
  logic [7:0] sectors_i;
  logic [7:0] rank_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] phase_out_o;

  int fail_count;
  int pending;
  int checked;
  int cycle_count;
  int burst_left;
  bit steady_stretch;
  int items_sent;
  int sent_by_op [4];

  phase_success_ranker_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .phase_code_i (phase_code_i),
    .sectors_i    (sectors_i),
    .rank_i       (rank_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phase_out_o  (phase_out_o)
  );

  phase_rank_checker rank_watch (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .op_i         (op_i),
    .phase_code_i (phase_code_i),
    .sectors_i    (sectors_i),
    .rank_i       (rank_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .phase_out_i  (phase_out_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Stall the receiver on a pattern that changes over the run.
  initial begin
    logic [15:0] stall_mask;
    int          stall_mode;
    int          slot;
    out_ready_i <= 1'b0;
    slot = 0;
    forever begin
      stall_mask = 16'($urandom);
      stall_mode = $urandom_range(0, 3);
      repeat (200) begin
        @(posedge clk_i);
        case (stall_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= stall_mask[slot % 16];
          2:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ((slot % 16) == 15);
        endcase
        slot++;
      end
    end
  end

  // End the run if it hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d answers outstanding", cycle_count, pending);
    $display("status: fail");
    $finish;
  end

  // Send one transaction, opening a random gap between bursts.
  task automatic drive_item(input op_e op, input logic [7:0] code,
                            input logic [7:0] amount, input logic [7:0] rk);
    int gap;
    if (burst_left == 0) begin
      gap = steady_stretch ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i   <= 1'b1;
    op_i         <= op;
    phase_code_i <= code;
    sectors_i    <= amount;
    rank_i       <= rk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sent_by_op[op]++;
    items_sent++;
  endtask

  // Hold the sender until every query answer has come back.
  task automatic wait_for_answers();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_rank();
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
  endfunction

  function automatic logic [7:0] pick_sectors();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
  endfunction

  initial begin
    logic [7:0] code;
    op_e        op;
    int         next_quiet;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    op_i         <= OP_SUBMIT;
    phase_code_i <= 8'h00;
    sectors_i    <= 8'h00;
    rank_i       <= 8'h00;
    burst_left     = 0;
    steady_stretch = 1'b0;
    items_sent     = 0;
    next_quiet     = QUIET_EVERY;
    for (int i = 0; i < 4; i++) sent_by_op[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Query the reset ranking, including out-of-range ranks.
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd0);
    drive_item(OP_QUERY, 8'hFF, 8'hFF, 8'd15);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd16);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd255);
    // Reorder with every counter tied.
    drive_item(OP_REORDER, 8'hFF, 8'hFF, 8'hFF);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd7);
    // Submit extremes of the sector count and unknown characters.
    drive_item(OP_SUBMIT, "0", 8'd255, 8'h00);
    drive_item(OP_SUBMIT, "8", 8'd0, 8'hFF);
    drive_item(OP_SUBMIT, "a", 8'd200, 8'h00);
    drive_item(OP_SUBMIT, 8'h00, 8'd255, 8'h00);
    drive_item(OP_SUBMIT, 8'hFF, 8'd255, 8'h00);
    drive_item(OP_SUBMIT, "F", 8'd1, 8'h00);
    drive_item(OP_SUBMIT, "9", 8'd255, 8'h00);
    // Rank with a tie at the top, then read the leaders.
    drive_item(OP_REORDER, 8'h00, 8'h00, 8'h00);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd0);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd1);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd2);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd128);
    // Clear and confirm the identity order is back.
    drive_item(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd0);
    drive_item(OP_QUERY, 8'h00, 8'h00, 8'd3);

    // Mostly track reads: submits, a reorder, a few queries; the rest is noise.
    while (items_sent < ITEM_TARGET) begin
      if ((items_sent % 100) < 20) steady_stretch = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) != 0) begin
        repeat ($urandom_range(2, 12)) begin
          code = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                            : PHASE_CHARS[$urandom_range(0, PHASE_COUNT - 1)];
          drive_item(OP_SUBMIT, code, pick_sectors(), 8'($urandom));
        end
        drive_item(OP_REORDER, 8'($urandom), 8'($urandom), 8'($urandom));
        repeat ($urandom_range(1, 4))
          drive_item(OP_QUERY, 8'($urandom), 8'($urandom), pick_rank());
      end else begin
        op = op_e'(2'($urandom_range(0, 3)));
        if (op == OP_CLEAR && $urandom_range(0, 4) != 0) op = OP_QUERY;
        drive_item(op, 8'($urandom), pick_sectors(), pick_rank());
      end
      if (items_sent >= next_quiet) begin
        wait_for_answers();
        next_quiet += QUIET_EVERY;
      end
    end

    // Drain outstanding answers and let a trailing reorder finish.
    wait_for_answers();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d transactions: %0d submit, %0d reorder, %0d query, %0d clear",
             items_sent, sent_by_op[OP_SUBMIT], sent_by_op[OP_REORDER],
             sent_by_op[OP_QUERY], sent_by_op[OP_CLEAR]);
    $display("checked %0d query answers, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
